@@ rtl/core/assert_macros.svh @@
// Assertion shorthands shared by the core RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define BA_ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

@@ rtl/core/box_avg_pkg.sv @@
package box_avg_pkg;

    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_BIN       = 16;
    localparam int HEIGHT_LIMIT  = 1024;

    localparam int PIX_W     = 8;
    localparam int BIN_W     = 5;
    localparam int DIM_W     = 11;
    localparam int COL_W     = $clog2(MAX_OUT_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int SUB_W     = $clog2(MAX_BIN);
    localparam int AREA_W    = 2 * BIN_W;
    // Largest block sum is 255 * MAX_BIN * MAX_BIN.
    localparam int SUM_W     = PIX_W + 2 * SUB_W;
    localparam int CFG_W     = DIM_W;
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 4;
    // The mean never exceeds 255, so one quotient bit per step for PIX_W steps.
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WITH_ALPHA = 2'd3;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] alpha;
    } sum_entry_t;

endpackage

@@ rtl/core/box_average_downsampler_core.sv @@
// Box-average downsampler for RGBA or RGB pixels.
// Source pixels enter on the in channel (in_valid, in_stall) in raster order, lowest
// row first. Every bin_factor by bin_factor block of source pixels gives one result
// item on the out channel (out_valid, out_stall) carrying the truncated channel means,
// the output column and row, and frame_done on the last pixel of the frame.
// Configuration is written through cfg_write, cfg_index and cfg_data; every write
// restarts the frame; the user must only do so while the block is idle (unchecked).
// Per-column channel sums live in a 1024-entry memory with a registered read; each
// item is read on acceptance and written back on the next cycle, with a bypass when
// consecutive items hit the same column.
// Items that do not close a block are taken one per cycle. An item that closes a
// block hands its sums to a shared restoring divider, one quotient bit per cycle, and
// the input stalls while it runs. The divider hands the result to the output register
// that drives out_valid.
// A result waits in the output register while later items are taken; the input
// stalls only if a second result is ready before the first has been taken.
// Reset restores the configuration registers to 1 and clears the counters and the
// pipeline; the sum memory is not cleared, as a block's first item does not use it.
`include "assert_macros.svh"

module box_average_downsampler_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [box_avg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [box_avg_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [box_avg_pkg::PIX_W-1:0]         red_in,
    input  logic [box_avg_pkg::PIX_W-1:0]         green_in,
    input  logic [box_avg_pkg::PIX_W-1:0]         blue_in,
    input  logic [box_avg_pkg::PIX_W-1:0]         alpha_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [box_avg_pkg::PIX_W-1:0]         red_out,
    output logic [box_avg_pkg::PIX_W-1:0]         green_out,
    output logic [box_avg_pkg::PIX_W-1:0]         blue_out,
    output logic [box_avg_pkg::PIX_W-1:0]         alpha_out,
    output logic [box_avg_pkg::COL_W-1:0]         out_col,
    output logic [box_avg_pkg::ROW_W-1:0]         out_row,
    output logic                                  frame_done
);

    // Configuration registers
    logic [box_avg_pkg::BIN_W-1:0] bin_factor_reg;
    logic [box_avg_pkg::DIM_W-1:0] out_width_reg;
    logic [box_avg_pkg::DIM_W-1:0] out_height_reg;
    logic                          with_alpha_reg;

    logic [box_avg_pkg::BIN_W-1:0]  bin_eff;
    logic [box_avg_pkg::BIN_W-1:0]  bin_m1;
    logic [box_avg_pkg::DIM_W-1:0]  w_eff;
    logic [box_avg_pkg::DIM_W-1:0]  h_eff;
    logic [box_avg_pkg::DIM_W-1:0]  w_m1;
    logic [box_avg_pkg::DIM_W-1:0]  h_m1;
    logic [box_avg_pkg::AREA_W-1:0] area;

    // Position counters
    logic [box_avg_pkg::SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [box_avg_pkg::SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [box_avg_pkg::COL_W-1:0] block_col_reg, block_col_next;
    logic [box_avg_pkg::ROW_W-1:0] block_row_reg, block_row_next;
    logic [box_avg_pkg::DIM_W-1:0] col_inc;
    logic [box_avg_pkg::DIM_W-1:0] row_inc;

    logic                accept;
    logic                first_s0;
    logic                last_s0;
    logic                done_s0;
    box_avg_pkg::pixel_t pix_s0;

    // Read-modify-write stage
    logic                          p1_valid_reg;
    logic                          p1_first_reg;
    logic                          p1_last_reg;
    logic                          p1_done_reg;
    logic [box_avg_pkg::COL_W-1:0] p1_col_reg;
    logic [box_avg_pkg::ROW_W-1:0] p1_row_reg;
    box_avg_pkg::pixel_t           p1_pix_reg;

    box_avg_pkg::sum_entry_t col_sum_mem [box_avg_pkg::MAX_OUT_WIDTH];
    box_avg_pkg::sum_entry_t rd_data_reg;
    box_avg_pkg::sum_entry_t base_sum;
    box_avg_pkg::sum_entry_t acc_sum;

    logic                          wr_valid_reg;
    logic [box_avg_pkg::COL_W-1:0] wr_col_reg;
    box_avg_pkg::sum_entry_t       wr_sum_reg;
    logic                          bypass;

    // Divider
    logic                           div_load;
    logic                           div_active_reg;
    logic [box_avg_pkg::STEP_W-1:0] div_left_reg;
    logic                           div_handoff;
    logic [box_avg_pkg::SUM_W-1:0]  div_den_reg;
    logic [box_avg_pkg::SUM_W-1:0]  div_rem_reg  [box_avg_pkg::LANES];
    logic [box_avg_pkg::PIX_W-1:0]  div_quo_reg  [box_avg_pkg::LANES];
    logic [box_avg_pkg::SUM_W-1:0]  div_rem_next [box_avg_pkg::LANES];
    logic [box_avg_pkg::PIX_W-1:0]  div_quo_next [box_avg_pkg::LANES];
    logic [box_avg_pkg::SUM_W-1:0]  load_sum     [box_avg_pkg::LANES];
    logic [box_avg_pkg::COL_W-1:0]  div_col_reg;
    logic [box_avg_pkg::ROW_W-1:0]  div_row_reg;
    logic                           div_done_reg;

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_factor_reg <= box_avg_pkg::BIN_W'(1);
            out_width_reg  <= box_avg_pkg::DIM_W'(1);
            out_height_reg <= box_avg_pkg::DIM_W'(1);
            with_alpha_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                box_avg_pkg::CFG_BIN_FACTOR: bin_factor_reg <= cfg_data[box_avg_pkg::BIN_W-1:0];
                box_avg_pkg::CFG_OUT_WIDTH:  out_width_reg  <= cfg_data[box_avg_pkg::DIM_W-1:0];
                box_avg_pkg::CFG_OUT_HEIGHT: out_height_reg <= cfg_data[box_avg_pkg::DIM_W-1:0];
                box_avg_pkg::CFG_WITH_ALPHA: with_alpha_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings fall back to the nearest legal value.
    always_comb
    begin
        if (bin_factor_reg == '0)
            bin_eff = box_avg_pkg::BIN_W'(1);
        else if (bin_factor_reg > box_avg_pkg::BIN_W'(box_avg_pkg::MAX_BIN))
            bin_eff = box_avg_pkg::BIN_W'(box_avg_pkg::MAX_BIN);
        else
            bin_eff = bin_factor_reg;

        if (out_width_reg == '0)
            w_eff = box_avg_pkg::DIM_W'(1);
        else if (out_width_reg > box_avg_pkg::DIM_W'(box_avg_pkg::MAX_OUT_WIDTH))
            w_eff = box_avg_pkg::DIM_W'(box_avg_pkg::MAX_OUT_WIDTH);
        else
            w_eff = out_width_reg;

        if (out_height_reg == '0)
            h_eff = box_avg_pkg::DIM_W'(1);
        else if (out_height_reg > box_avg_pkg::DIM_W'(box_avg_pkg::HEIGHT_LIMIT))
            h_eff = box_avg_pkg::DIM_W'(box_avg_pkg::HEIGHT_LIMIT);
        else
            h_eff = out_height_reg;
    end

    assign bin_m1 = bin_eff - box_avg_pkg::BIN_W'(1);
    assign w_m1   = w_eff - box_avg_pkg::DIM_W'(1);
    assign h_m1   = h_eff - box_avg_pkg::DIM_W'(1);
    assign area   = box_avg_pkg::AREA_W'(bin_eff) * box_avg_pkg::AREA_W'(bin_eff);

    // A block that completes must reach the divider before the next item is taken.
    assign in_stall = div_active_reg || (p1_valid_reg && p1_last_reg);
    assign accept   = in_valid && !in_stall;

    assign first_s0 = (sub_col_reg == '0) && (sub_row_reg == '0);
    assign last_s0  = ({1'b0, sub_col_reg} == bin_m1) && ({1'b0, sub_row_reg} == bin_m1);
    assign done_s0  = ({1'b0, block_col_reg} == w_m1) && ({1'b0, block_row_reg} == h_m1);

    assign pix_s0.red   = red_in;
    assign pix_s0.green = green_in;
    assign pix_s0.blue  = blue_in;
    assign pix_s0.alpha = with_alpha_reg ? alpha_in : '0;

    assign col_inc = box_avg_pkg::DIM_W'(block_col_reg) + box_avg_pkg::DIM_W'(1);
    assign row_inc = box_avg_pkg::DIM_W'(block_row_reg) + box_avg_pkg::DIM_W'(1);

    always_comb
    begin
        sub_col_next   = sub_col_reg;
        sub_row_next   = sub_row_reg;
        block_col_next = block_col_reg;
        block_row_next = block_row_reg;
        if (cfg_write)
        begin
            sub_col_next   = '0;
            sub_row_next   = '0;
            block_col_next = '0;
            block_row_next = '0;
        end
        else if (accept)
        begin
            if ({1'b0, sub_col_reg} == bin_m1)
            begin
                sub_col_next = '0;
                if (col_inc >= w_eff)
                begin
                    block_col_next = '0;
                    if ({1'b0, sub_row_reg} == bin_m1)
                    begin
                        sub_row_next = '0;
                        if (row_inc >= h_eff)
                            block_row_next = '0;
                        else
                            block_row_next = row_inc[box_avg_pkg::ROW_W-1:0];
                    end
                    else
                    begin
                        sub_row_next = sub_row_reg + box_avg_pkg::SUB_W'(1);
                    end
                end
                else
                begin
                    block_col_next = col_inc[box_avg_pkg::COL_W-1:0];
                end
            end
            else
            begin
                sub_col_next = sub_col_reg + box_avg_pkg::SUB_W'(1);
            end
        end
    end

    // The write of the previous item lands in the same cycle as this item's read,
    // so a matching column takes the freshly written sum instead of memory data.
    assign bypass = wr_valid_reg && (wr_col_reg == p1_col_reg);

    always_comb
    begin
        if (p1_first_reg)
            base_sum = '0;
        else if (bypass)
            base_sum = wr_sum_reg;
        else
            base_sum = rd_data_reg;
        acc_sum.red   = base_sum.red   + box_avg_pkg::SUM_W'(p1_pix_reg.red);
        acc_sum.green = base_sum.green + box_avg_pkg::SUM_W'(p1_pix_reg.green);
        acc_sum.blue  = base_sum.blue  + box_avg_pkg::SUM_W'(p1_pix_reg.blue);
        acc_sum.alpha = base_sum.alpha + box_avg_pkg::SUM_W'(p1_pix_reg.alpha);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= col_sum_mem[block_col_reg];
        if (p1_valid_reg)
            col_sum_mem[p1_col_reg] <= acc_sum;
    end

    assign div_load    = p1_valid_reg && p1_last_reg;
    assign div_handoff = div_active_reg && (div_left_reg == '0)
                         && (!out_valid_reg || !out_stall);

    assign load_sum[box_avg_pkg::LANE_RED]   = acc_sum.red;
    assign load_sum[box_avg_pkg::LANE_GREEN] = acc_sum.green;
    assign load_sum[box_avg_pkg::LANE_BLUE]  = acc_sum.blue;
    assign load_sum[box_avg_pkg::LANE_ALPHA] = acc_sum.alpha;

    // One restoring step per lane: the quotient is known to fit in PIX_W bits.
    always_comb
    begin
        for (int i = 0; i < box_avg_pkg::LANES; i++)
        begin
            if (div_rem_reg[i] >= div_den_reg)
            begin
                div_rem_next[i] = div_rem_reg[i] - div_den_reg;
                div_quo_next[i] = {div_quo_reg[i][box_avg_pkg::PIX_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next[i] = div_rem_reg[i];
                div_quo_next[i] = {div_quo_reg[i][box_avg_pkg::PIX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg    <= '0;
            sub_row_reg    <= '0;
            block_col_reg  <= '0;
            block_row_reg  <= '0;
            p1_valid_reg   <= 1'b0;
            wr_valid_reg   <= 1'b0;
            div_active_reg <= 1'b0;
            div_left_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sub_col_reg   <= sub_col_next;
            sub_row_reg   <= sub_row_next;
            block_col_reg <= block_col_next;
            block_row_reg <= block_row_next;
            p1_valid_reg  <= accept;
            wr_valid_reg  <= p1_valid_reg;

            if (div_load)
            begin
                div_active_reg <= 1'b1;
                div_left_reg   <= box_avg_pkg::STEP_W'(box_avg_pkg::DIV_STEPS);
            end
            else if (div_handoff)
            begin
                div_active_reg <= 1'b0;
            end
            else if (div_active_reg && (div_left_reg != '0))
            begin
                div_left_reg <= div_left_reg - box_avg_pkg::STEP_W'(1);
            end

            if (div_handoff)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_first_reg <= first_s0;
            p1_last_reg  <= last_s0;
            p1_done_reg  <= done_s0;
            p1_col_reg   <= block_col_reg;
            p1_row_reg   <= block_row_reg;
            p1_pix_reg   <= pix_s0;
        end

        if (p1_valid_reg)
        begin
            wr_col_reg <= p1_col_reg;
            wr_sum_reg <= acc_sum;
        end

        if (div_load)
        begin
            for (int i = 0; i < box_avg_pkg::LANES; i++)
            begin
                div_rem_reg[i] <= load_sum[i];
                div_quo_reg[i] <= '0;
            end
            div_den_reg  <= box_avg_pkg::SUM_W'(area) << (box_avg_pkg::DIV_STEPS - 1);
            div_col_reg  <= p1_col_reg;
            div_row_reg  <= p1_row_reg;
            div_done_reg <= p1_done_reg;
        end
        else if (div_active_reg && (div_left_reg != '0))
        begin
            for (int i = 0; i < box_avg_pkg::LANES; i++)
            begin
                div_rem_reg[i] <= div_rem_next[i];
                div_quo_reg[i] <= div_quo_next[i];
            end
            div_den_reg <= div_den_reg >> 1;
        end

        if (div_handoff)
        begin
            red_out    <= div_quo_reg[box_avg_pkg::LANE_RED];
            green_out  <= div_quo_reg[box_avg_pkg::LANE_GREEN];
            blue_out   <= div_quo_reg[box_avg_pkg::LANE_BLUE];
            alpha_out  <= div_quo_reg[box_avg_pkg::LANE_ALPHA];
            out_col    <= div_col_reg;
            out_row    <= div_row_reg;
            frame_done <= div_done_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `BA_ASSERT_IMPLIES(a_div_load_idle, div_load, !div_active_reg, "divider loaded while busy")
    `BA_ASSERT_IMPLIES(a_div_steps_active, div_left_reg != '0, div_active_reg, "divider stepping while idle")
    `BA_ASSERT_ALWAYS(a_sub_col_range, {1'b0, sub_col_reg} < bin_eff, "sub column beyond block size")
    `BA_ASSERT_ALWAYS(a_block_col_range, {1'b0, block_col_reg} < w_eff, "block column beyond width")

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 120;
    localparam int RANDOM_ITEMS  = 240;
    localparam int RANDOM_MEANS  = 30;
    localparam int CLAMP_ITEMS   = 20;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [box_avg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [box_avg_pkg::CFG_W-1:0]     cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [box_avg_pkg::PIX_W-1:0]     red_in;
    logic [box_avg_pkg::PIX_W-1:0]     green_in;
    logic [box_avg_pkg::PIX_W-1:0]     blue_in;
    logic [box_avg_pkg::PIX_W-1:0]     alpha_in;
    logic                              out_valid;
    logic                              out_stall;
    logic [box_avg_pkg::PIX_W-1:0]     red_out;
    logic [box_avg_pkg::PIX_W-1:0]     green_out;
    logic [box_avg_pkg::PIX_W-1:0]     blue_out;
    logic [box_avg_pkg::PIX_W-1:0]     alpha_out;
    logic [box_avg_pkg::COL_W-1:0]     out_col;
    logic [box_avg_pkg::ROW_W-1:0]     out_row;
    logic                              frame_done;

    typedef struct packed {
        logic [box_avg_pkg::PIX_W-1:0] red;
        logic [box_avg_pkg::PIX_W-1:0] green;
        logic [box_avg_pkg::PIX_W-1:0] blue;
        logic [box_avg_pkg::PIX_W-1:0] alpha;
        logic [box_avg_pkg::COL_W-1:0] col;
        logic [box_avg_pkg::ROW_W-1:0] row;
        logic                          done;
    } mean_pixel_t;

    mean_pixel_t expected_pixels[$];

    // Shadow copy of the registers and the block position within the frame.
    logic [box_avg_pkg::BIN_W-1:0] bin_reg;
    logic [box_avg_pkg::DIM_W-1:0] width_reg;
    logic [box_avg_pkg::DIM_W-1:0] height_reg;
    logic                          alpha_reg;
    int unsigned      sub_col;
    int unsigned      sub_row;
    int unsigned      block_col;
    int unsigned      block_row;
    int unsigned      red_acc[box_avg_pkg::MAX_OUT_WIDTH];
    int unsigned      green_acc[box_avg_pkg::MAX_OUT_WIDTH];
    int unsigned      blue_acc[box_avg_pkg::MAX_OUT_WIDTH];
    int unsigned      alpha_acc[box_avg_pkg::MAX_OUT_WIDTH];

    int unsigned      means_predicted;
    int               mismatches;
    bit               quiet;
    bit               hold_request;

    box_average_downsampler_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_done (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("box_average_downsampler_core regression: fail");
        $finish;
    end

    function automatic int unsigned limit_dim(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function void restart_counters();
        sub_col   = 0;
        sub_row   = 0;
        block_col = 0;
        block_row = 0;
    endfunction

    function void apply_register(input logic [box_avg_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [box_avg_pkg::CFG_W-1:0] data);
        case (idx)
            box_avg_pkg::CFG_BIN_FACTOR: bin_reg    = data[box_avg_pkg::BIN_W-1:0];
            box_avg_pkg::CFG_OUT_WIDTH:  width_reg  = data;
            box_avg_pkg::CFG_OUT_HEIGHT: height_reg = data;
            box_avg_pkg::CFG_WITH_ALPHA: alpha_reg  = data[0];
            default: ;
        endcase
        restart_counters();
    endfunction

    // Adds one source pixel to its column sum and queues the block mean when the
    // pixel closes a block.
    function void fold_pixel(input logic [box_avg_pkg::PIX_W-1:0] r,
                             input logic [box_avg_pkg::PIX_W-1:0] g,
                             input logic [box_avg_pkg::PIX_W-1:0] b,
                             input logic [box_avg_pkg::PIX_W-1:0] a);
        int unsigned bin;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned area;
        int unsigned a_used;
        mean_pixel_t m;
        bin    = limit_dim(bin_reg, box_avg_pkg::MAX_BIN);
        w      = limit_dim(width_reg, box_avg_pkg::MAX_OUT_WIDTH);
        h      = limit_dim(height_reg, box_avg_pkg::HEIGHT_LIMIT);
        a_used = alpha_reg ? a : 0;
        col    = block_col;
        if (col >= w)
            col = w - 1;
        if (sub_row == 0 && sub_col == 0)
        begin
            red_acc[col]   = r;
            green_acc[col] = g;
            blue_acc[col]  = b;
            alpha_acc[col] = a_used;
        end
        else
        begin
            red_acc[col]   += r;
            green_acc[col] += g;
            blue_acc[col]  += b;
            alpha_acc[col] += a_used;
        end
        if (sub_col == bin - 1 && sub_row == bin - 1)
        begin
            area    = bin * bin;
            m.red   = box_avg_pkg::PIX_W'(red_acc[col] / area);
            m.green = box_avg_pkg::PIX_W'(green_acc[col] / area);
            m.blue  = box_avg_pkg::PIX_W'(blue_acc[col] / area);
            m.alpha = alpha_reg ? box_avg_pkg::PIX_W'(alpha_acc[col] / area) : '0;
            m.col   = box_avg_pkg::COL_W'(col);
            m.row   = box_avg_pkg::ROW_W'(block_row);
            m.done  = (col == w - 1) && (block_row == h - 1);
            expected_pixels.push_back(m);
            means_predicted++;
        end
        sub_col++;
        if (sub_col >= bin)
        begin
            sub_col   = 0;
            block_col = col + 1;
            if (block_col >= w)
            begin
                block_col = 0;
                sub_row++;
                if (sub_row >= bin)
                begin
                    sub_row = 0;
                    block_row++;
                    if (block_row >= h)
                        block_row = 0;
                end
            end
        end
    endfunction

    task flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_result();
        mean_pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            flag_mismatch("unexpected item, out_col", out_col, 0);
            return;
        end
        want = expected_pixels.pop_front();
        if (red_out !== want.red)
            flag_mismatch("red_out", red_out, want.red);
        if (green_out !== want.green)
            flag_mismatch("green_out", green_out, want.green);
        if (blue_out !== want.blue)
            flag_mismatch("blue_out", blue_out, want.blue);
        if (alpha_out !== want.alpha)
            flag_mismatch("alpha_out", alpha_out, want.alpha);
        if (out_col !== want.col)
            flag_mismatch("out_col", out_col, want.col);
        if (out_row !== want.row)
            flag_mismatch("out_row", out_row, want.row);
        if (frame_done !== want.done)
            flag_mismatch("frame_done", frame_done, want.done);
    endtask

    // All handshakes are observed here, at the rising edge, before the block's
    // registers move.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                apply_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                fold_pixel(red_in, green_in, blue_in, alpha_in);
            if (out_valid && !out_stall)
                check_result();
        end
    end

    // Receiver: short random stalls, and one long hold-off when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [box_avg_pkg::PIX_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return box_avg_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one item and returns once it has been taken. Valid is left high so
    // that a following item can go straight after.
    task automatic send_pixel(input logic [box_avg_pkg::PIX_W-1:0] r,
                              input logic [box_avg_pkg::PIX_W-1:0] g,
                              input logic [box_avg_pkg::PIX_W-1:0] b,
                              input logic [box_avg_pkg::PIX_W-1:0] a);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        alpha_in <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(pick_level(), pick_level(), pick_level(), pick_level());
    endtask

    // Waits until every queued mean has come out and the block has gone quiet.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [box_avg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [box_avg_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic reconfigure(input logic [box_avg_pkg::CFG_W-1:0] bin_word,
                               input logic [box_avg_pkg::CFG_W-1:0] w_word,
                               input logic [box_avg_pkg::CFG_W-1:0] h_word,
                               input logic [box_avg_pkg::CFG_W-1:0] a_word);
        settle_block();
        write_reg(box_avg_pkg::CFG_BIN_FACTOR, bin_word);
        write_reg(box_avg_pkg::CFG_OUT_WIDTH, w_word);
        write_reg(box_avg_pkg::CFG_OUT_HEIGHT, h_word);
        write_reg(box_avg_pkg::CFG_WITH_ALPHA, a_word);
    endtask

    // After reset every register is one, so each item is a whole frame.
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3);
    endtask

    task automatic test_directed_cases();
        // RGB mode: alpha input is ignored, and the first block truncates to
        // red 1, green 0 and blue 254.
        reconfigure(2, 2, 1, 0);
        send_pixel(8'd1, 8'd0, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd17);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd17);
        send_pixel(8'd1, 8'd1, 8'd254, 8'd255);
        send_pixel(8'd2, 8'd1, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd17);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd3);
        // Zero block size, width and height all behave as one.
        reconfigure(0, 0, 0, 1);
        send_pixel(8'd7, 8'd200, 8'd0, 8'd128);
        send_pixel(8'd255, 8'd1, 8'd2, 8'd3);
    endtask

    task automatic test_block_extremes();
        // An oversized block acts as the largest one; all-white gives the largest sum.
        reconfigure(31, 1, 1, 1);
        repeat (box_avg_pkg::MAX_BIN * box_avg_pkg::MAX_BIN) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Oversized width and height are taken as the largest values.
        reconfigure(1, 2047, 1, 0);
        repeat (CLAMP_ITEMS) send_random_pixel();
        reconfigure(1, 1, 2047, 1);
        repeat (CLAMP_ITEMS) send_random_pixel();
    endtask

    task automatic test_backpressure();
        reconfigure(1, 4, 2, 1);
        hold_request = 1'b1;
        repeat (40) send_random_pixel();
    endtask

    // Mostly whole frames with random content on small formats, some cut short,
    // with the odd oversized or zero register value.
    task automatic test_random_frames();
        int unsigned items_sent;
        int unsigned means_start;
        int unsigned bin;
        int unsigned w;
        int unsigned h;
        int unsigned frame_len;
        int unsigned n;
        logic [box_avg_pkg::CFG_W-1:0] bin_word;
        logic [box_avg_pkg::CFG_W-1:0] a_word;
        items_sent  = 0;
        means_start = means_predicted;
        while (items_sent < RANDOM_ITEMS || means_predicted - means_start < RANDOM_MEANS)
        begin
            case ($urandom_range(0, 9))
                0: bin = 0;
                1: bin = $urandom_range(box_avg_pkg::MAX_BIN + 1, 31);
                2: bin = $urandom_range(5, box_avg_pkg::MAX_BIN);
                default: bin = $urandom_range(1, 3);
            endcase
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = $urandom_range(1000, 2047);
                default: w = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0: h = 0;
                1: h = $urandom_range(1000, 2047);
                default: h = $urandom_range(1, 4);
            endcase
            // Bits above a register's width are junk that the block must drop.
            bin_word = box_avg_pkg::CFG_W'(bin | ($urandom_range(0, 63) << box_avg_pkg::BIN_W));
            a_word   = box_avg_pkg::CFG_W'($urandom_range(0, 1) | ($urandom_range(0, 1023) << 1));
            reconfigure(bin_word, box_avg_pkg::CFG_W'(w), box_avg_pkg::CFG_W'(h), a_word);
            frame_len = limit_dim(bin, box_avg_pkg::MAX_BIN) * limit_dim(bin, box_avg_pkg::MAX_BIN)
                        * limit_dim(w, box_avg_pkg::MAX_OUT_WIDTH)
                        * limit_dim(h, box_avg_pkg::HEIGHT_LIMIT);
            if (frame_len <= 240)
            begin
                n = frame_len * $urandom_range(1, 2);
                if ($urandom_range(0, 2) == 0)
                    n += $urandom_range(1, frame_len);
            end
            else
                n = $urandom_range(1, 200);
            repeat (n) send_random_pixel();
            items_sent += n;
        end
    endtask

    task automatic test_streaming_tail();
        reconfigure(2, 3, 2, 0);
        quiet = 1'b1;
        repeat (48) send_random_pixel();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = box_avg_pkg::CFG_BIN_FACTOR;
        cfg_data     = '0;
        in_valid     = 1'b0;
        red_in       = '0;
        green_in     = '0;
        blue_in      = '0;
        alpha_in     = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        means_predicted = 0;
        bin_reg      = box_avg_pkg::BIN_W'(1);
        width_reg    = box_avg_pkg::DIM_W'(1);
        height_reg   = box_avg_pkg::DIM_W'(1);
        alpha_reg    = 1'b1;
        restart_counters();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_block_extremes();
        test_backpressure();
        test_random_frames();
        test_streaming_tail();
        settle_block();

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("box_average_downsampler_core regression: pass");
        else
            $display("box_average_downsampler_core regression: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/box_avg_pkg.sv
rtl/core/box_average_downsampler_core.sv
tb/tb_top.sv
